@@ hw/rtl/dmic_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dmic_pkg
// Shared widths, command codes and types of the direct-mapped instruction
// cache. Line count and words per line are powers of two.
// ----------------------------------------------------------------------------
package dmic_pkg;

    localparam int CMD_W      = 2;
    localparam int INDEX_IN_W = 9;
    localparam int ADDR_W     = 32;
    localparam int WORD_W     = 32;
    localparam int TAG_LSB    = 12;
    localparam int TAG_W      = ADDR_W - TAG_LSB;
    localparam int OFFSET_LSB = 2;

    localparam int LINE_COUNT_DEFAULT     = 512;
    localparam int WORDS_PER_LINE_DEFAULT = 8;

    localparam logic [CMD_W-1:0] CMD_PROBE      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INVALIDATE = 2'd2;

    typedef struct packed {
        logic             probe;
        logic [TAG_W-1:0] tag;
    } dmic_req_t;

endpackage
`default_nettype wire

@@ hw/rtl/dmic_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dmic_ram
// Generic simple dual-port RAM with one write port and one registered read
// port. Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module dmic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ hw/rtl/dmic_sweep.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dmic_sweep
// Clearing sequencer. After reset and after each invalidate it walks the tag
// memory one line per cycle so that every line reads as invalid.
// ----------------------------------------------------------------------------
module dmic_sweep #(
    parameter int LINE_COUNT = dmic_pkg::LINE_COUNT_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               active,
    output logic [$clog2(LINE_COUNT)-1:0]      index
);

    localparam int IDX_W = $clog2(LINE_COUNT);

    logic             active_reg;
    logic             active_next;
    logic [IDX_W-1:0] count_reg;
    logic [IDX_W-1:0] count_next;

    always_comb
    begin
        active_next = active_reg;
        count_next  = count_reg;
        if (active_reg)
        begin
            if (count_reg == IDX_W'(LINE_COUNT - 1))
            begin
                active_next = 1'b0;
                count_next  = '0;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (start)
        begin
            active_next = 1'b1;
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            count_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            count_reg  <= count_next;
        end
    end

    assign active = active_reg;
    assign index  = count_reg;

endmodule
`default_nettype wire

@@ hw/rtl/dmic_lookup.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dmic_lookup
// Read stage and output register. It compares the stored tag with the probe
// tag once the memories return data and holds the result until taken.
// ----------------------------------------------------------------------------
module dmic_lookup (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         issue,
    input  wire dmic_pkg::dmic_req_t          req,
    input  wire logic [dmic_pkg::TAG_W:0]     tag_rdata,
    input  wire logic [dmic_pkg::WORD_W-1:0]  word_rdata,
    input  wire logic                         out_stall,
    output logic                              ready,
    output logic                              out_valid,
    output logic                              hit,
    output logic [dmic_pkg::WORD_W-1:0]       instruction_word
);

    import dmic_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    dmic_req_t   s1_req_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        hit_reg;
    logic        hit_next;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic        advance;
    logic        match;

    assign advance = !out_valid_reg || !out_stall;
    assign ready   = !s1_valid_reg || advance;
    assign match   = s1_req_reg.probe && tag_rdata[TAG_W]
                     && (tag_rdata[TAG_W-1:0] == s1_req_reg.tag);

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        word_next      = word_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
            hit_next       = match;
            word_next      = match ? word_rdata : '0;
            s1_valid_next  = 1'b0;
        end
        if (issue)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_req_reg <= req;
        end
        hit_reg  <= hit_next;
        word_reg <= word_next;
    end

    assign out_valid        = out_valid_reg;
    assign hit              = hit_reg;
    assign instruction_word = word_reg;

endmodule
`default_nettype wire

@@ hw/rtl/direct_mapped_icache_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// direct_mapped_icache_unit
// A result passes the memory read registers, then the output register.
// Throughput: one word per cycle unless a sweep or out_stall holds the input,
// set by the single read port of each memory. An invalidate, and reset, start
// a sweep that clears every valid bit of the tag memory; no word is accepted during the sweep.
// ----------------------------------------------------------------------------
module direct_mapped_icache_unit #(
    parameter int LINE_COUNT     = dmic_pkg::LINE_COUNT_DEFAULT,
    parameter int WORDS_PER_LINE = dmic_pkg::WORDS_PER_LINE_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [dmic_pkg::CMD_W-1:0]       command,
    input  wire logic [dmic_pkg::INDEX_IN_W-1:0]  line_index,
    input  wire logic [dmic_pkg::ADDR_W-1:0]      phys_address,
    input  wire logic [dmic_pkg::WORD_W-1:0]      fill_word,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  hit,
    output logic [dmic_pkg::WORD_W-1:0]           instruction_word
);

    import dmic_pkg::*;

    localparam int IDX_W = $clog2(LINE_COUNT);
    localparam int OFF_W = $clog2(WORDS_PER_LINE);

    logic             accept;
    logic             ready;
    logic             sweep_active;
    logic [IDX_W-1:0] sweep_index;
    logic [IDX_W-1:0] line_sel;
    logic [OFF_W-1:0] offset;
    logic             is_probe;
    logic             is_fill;
    logic             is_inval;
    logic [TAG_W-1:0] tag;
    dmic_req_t        req;

    logic             tag_we;
    logic [IDX_W-1:0] tag_waddr;
    logic [TAG_W:0]   tag_wdata;
    logic [TAG_W:0]   tag_rdata;
    logic [WORD_W-1:0] word_rdata;

    generate
        if (IDX_W <= INDEX_IN_W)
        begin : g_idx_narrow
            assign line_sel = line_index[IDX_W-1:0];
        end
        else
        begin : g_idx_wide
            assign line_sel = {{(IDX_W - INDEX_IN_W){1'b0}}, line_index};
        end
    endgenerate

    assign offset   = phys_address[OFFSET_LSB +: OFF_W];
    assign tag      = phys_address[ADDR_W-1:TAG_LSB];
    assign is_probe = (command == CMD_PROBE);
    assign is_fill  = (command == CMD_FILL);
    assign is_inval = (command == CMD_INVALIDATE);

    assign in_stall = sweep_active || !ready;
    assign accept   = in_valid && !in_stall;

    assign req.probe = is_probe;
    assign req.tag   = tag;

    assign tag_we    = sweep_active || (accept && is_fill);
    assign tag_waddr = sweep_active ? sweep_index : line_sel;
    assign tag_wdata = sweep_active ? '0 : {1'b1, tag};

    dmic_sweep #(
        .LINE_COUNT (LINE_COUNT)
    ) u_sweep (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept && is_inval),
        .active (sweep_active),
        .index  (sweep_index)
    );

    dmic_ram #(
        .WIDTH (TAG_W + 1),
        .DEPTH (LINE_COUNT)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (accept && is_probe),
        .raddr (line_sel),
        .rdata (tag_rdata)
    );

    dmic_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LINE_COUNT * WORDS_PER_LINE)
    ) u_word_ram (
        .clk   (clk),
        .we    (accept && is_fill),
        .waddr ({line_sel, offset}),
        .wdata (fill_word),
        .re    (accept && is_probe),
        .raddr ({line_sel, offset}),
        .rdata (word_rdata)
    );

    dmic_lookup u_lookup (
        .clk              (clk),
        .rst_n            (rst_n),
        .issue            (accept),
        .req              (req),
        .tag_rdata        (tag_rdata),
        .word_rdata       (word_rdata),
        .out_stall        (out_stall),
        .ready            (ready),
        .out_valid        (out_valid),
        .hit              (hit),
        .instruction_word (instruction_word)
    );

endmodule
`default_nettype wire

@@ hw/rtl/dmic_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dmic_checker
// Port-level checks of the instruction cache, bound to the top level.
// ----------------------------------------------------------------------------
module dmic_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic                             in_stall,
    input  wire logic [dmic_pkg::CMD_W-1:0]       command,
    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire logic                             hit,
    input  wire logic [dmic_pkg::WORD_W-1:0]      instruction_word
);

    import dmic_pkg::*;

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(instruction_word))
        else $error("stalled result changed");

    // A miss or a non-probe result carries a zero word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> instruction_word == '0)
        else $error("miss result with nonzero word");

    // The clearing sweep after reset blocks the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall)
        else $error("input accepted during reset sweep");

    // An accepted invalidate starts a sweep that blocks the next word.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == CMD_INVALIDATE |=> in_stall)
        else $error("input accepted during invalidate sweep");

endmodule

bind direct_mapped_icache_unit dmic_checker u_checker (.*);
`default_nettype wire

@@ verif/direct_mapped_icache_checker.sv @@
// ----------------------------------------------------------------------------
// Direct-mapped instruction cache result checker
// Watches both channels of the cache, keeps its own copy of the line valid
// bits, tags and words, predicts hit and word for every accepted input word,
// and compares each accepted result with the oldest prediction. A mismatch
// count and the number of outstanding predictions go back to the testbench.
// ----------------------------------------------------------------------------
module direct_mapped_icache_checker #(
    parameter int LINE_COUNT     = dmic_pkg::LINE_COUNT_DEFAULT,
    parameter int WORDS_PER_LINE = dmic_pkg::WORDS_PER_LINE_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic                             in_stall,
    input  wire logic [dmic_pkg::CMD_W-1:0]       command,
    input  wire logic [dmic_pkg::INDEX_IN_W-1:0]  line_index,
    input  wire logic [dmic_pkg::ADDR_W-1:0]      phys_address,
    input  wire logic [dmic_pkg::WORD_W-1:0]      fill_word,
    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire logic                             hit,
    input  wire logic [dmic_pkg::WORD_W-1:0]      instruction_word,
    input  wire logic                             run_done,
    output int unsigned                           mismatch_count,
    output int unsigned                           pending_count,
    output int unsigned                           probe_count,
    output int unsigned                           hit_count,
    output int unsigned                           fill_count,
    output int unsigned                           wipe_count
);
    import dmic_pkg::*;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] word;
    } fetch_result_t;

    bit [LINE_COUNT-1:0] line_live;
    logic [TAG_W-1:0]    line_tags [LINE_COUNT];
    logic [WORD_W-1:0]   line_data [LINE_COUNT*WORDS_PER_LINE];
    fetch_result_t       expected_fetches [$];
    fetch_result_t       oldest_fetch;
    int unsigned         failures;
    int unsigned         probes;
    int unsigned         hits;
    int unsigned         fills;
    int unsigned         wipes;
    bit                  leftover_checked;

    assign probe_count = probes;
    assign hit_count   = hits;
    assign fill_count  = fills;
    assign wipe_count  = wipes;

    function automatic fetch_result_t predict_fetch(
        input logic [CMD_W-1:0]      cmd,
        input logic [INDEX_IN_W-1:0] index,
        input logic [ADDR_W-1:0]     addr,
        input logic [WORD_W-1:0]     data
    );
        int unsigned   line;
        int unsigned   slot;
        logic [TAG_W-1:0] tag;
        fetch_result_t res;
        line = index % LINE_COUNT;
        slot = line * WORDS_PER_LINE + (addr >> OFFSET_LSB) % WORDS_PER_LINE;
        tag  = addr[ADDR_W-1:TAG_LSB];
        res  = '0;
        case (cmd)
            CMD_PROBE:
            begin
                if (line_live[line] && line_tags[line] == tag)
                begin
                    res.hit  = 1'b1;
                    res.word = line_data[slot];
                end
            end
            CMD_FILL:
            begin
                line_data[slot] = data;
                line_tags[line] = tag;
                line_live[line] = 1'b1;
            end
            CMD_INVALIDATE:
            begin
                line_live = '0;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_live = '0;
            expected_fetches.delete();
            failures = 0;
            probes = 0;
            hits = 0;
            fills = 0;
            wipes = 0;
            leftover_checked = 1'b0;
            mismatch_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_fetches.push_back(
                    predict_fetch(command, line_index, phys_address, fill_word));
                if (command == CMD_PROBE)
                    probes++;
                else if (command == CMD_FILL)
                    fills++;
                else if (command == CMD_INVALIDATE)
                    wipes++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_fetches.size() == 0)
                begin
                    $error("Result with nothing expected: hit %0b, instruction_word %h.",
                           hit, instruction_word);
                    failures++;
                end
                else
                begin
                    oldest_fetch = expected_fetches.pop_front();
                    if (oldest_fetch.hit)
                        hits++;
                    if (hit !== oldest_fetch.hit)
                    begin
                        $error("Field hit: expected %0b, actual %0b.",
                               oldest_fetch.hit, hit);
                        failures++;
                    end
                    if (instruction_word !== oldest_fetch.word)
                    begin
                        $error("Field instruction_word: expected %h, actual %h.",
                               oldest_fetch.word, instruction_word);
                        failures++;
                    end
                end
            end
            if (run_done && !leftover_checked)
            begin
                leftover_checked = 1'b1;
                if (expected_fetches.size() != 0)
                begin
                    $error("%0d expected results never arrived.", expected_fetches.size());
                    failures++;
                end
            end
            mismatch_count <= failures;
            pending_count <= expected_fetches.size();
        end
    end

endmodule

@@ verif/direct_mapped_icache_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Direct-mapped instruction cache testbench
// Drives directed probes, line fills, invalidates and unused commands, then
// random runs of line fills, probe bursts, invalidates and unused commands over a small
// pool of lines and tags, under several mixes of sender idling and receiver stalling
// and one long output hold. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module direct_mapped_icache_unit_tb;
    import dmic_pkg::*;

    localparam int LINES          = LINE_COUNT_DEFAULT;
    localparam int WORDS          = WORDS_PER_LINE_DEFAULT;
    localparam int OFF_W          = $clog2(WORDS);
    localparam int LINE_POOL_SIZE = 16;
    localparam int TAG_POOL_SIZE  = 4;
    localparam int PHASE_ITEMS    = 360;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_LIMIT    = 20000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic [CMD_W-1:0]      command = CMD_PROBE;
    logic [INDEX_IN_W-1:0] line_index = '0;
    logic [ADDR_W-1:0]     phys_address = '0;
    logic [WORD_W-1:0]     fill_word = '0;
    logic                  out_stall = 1'b0;
    logic                  run_done = 1'b0;
    logic                  hold_request = 1'b0;
    logic                  hold_active = 1'b0;
    wire                   in_stall;
    wire                   out_valid;
    wire                   hit;
    wire [WORD_W-1:0]      instruction_word;

    int unsigned mismatch_count;
    int unsigned pending_count;
    int unsigned probe_count;
    int unsigned hit_count;
    int unsigned fill_count;
    int unsigned wipe_count;

    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned items_sent = 0;

    bit [LINES-1:0]        mirror_live;
    logic [TAG_W-1:0]      mirror_tag [LINES];
    bit [LINES*WORDS-1:0]  mirror_written;
    logic [INDEX_IN_W-1:0] line_pool [LINE_POOL_SIZE];
    logic [TAG_W-1:0]      tag_pool [TAG_POOL_SIZE];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    direct_mapped_icache_unit uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .line_index       (line_index),
        .phys_address     (phys_address),
        .fill_word        (fill_word),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .hit              (hit),
        .instruction_word (instruction_word)
    );

    direct_mapped_icache_checker fetch_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .line_index       (line_index),
        .phys_address     (phys_address),
        .fill_word        (fill_word),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .hit              (hit),
        .instruction_word (instruction_word),
        .run_done         (run_done),
        .mismatch_count   (mismatch_count),
        .pending_count    (pending_count),
        .probe_count      (probe_count),
        .hit_count        (hit_count),
        .fill_count       (fill_count),
        .wipe_count       (wipe_count)
    );

    initial
    begin
        #8000000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_active || ($urandom_range(0, 99) < stall_pct);
    end

    initial
    begin
        @(posedge hold_request);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    function automatic logic [ADDR_W-1:0] make_address(input logic [TAG_W-1:0] tag,
                                                        input int unsigned offset);
        logic [ADDR_W-1:0] addr;
        addr = $urandom;
        addr[ADDR_W-1:TAG_LSB] = tag;
        addr[OFFSET_LSB +: OFF_W] = offset[OFF_W-1:0];
        return addr;
    endfunction

    function automatic logic [INDEX_IN_W-1:0] pick_line();
        if ($urandom_range(0, 99) < 85)
            return line_pool[$urandom_range(0, LINE_POOL_SIZE-1)];
        return INDEX_IN_W'($urandom);
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        if ($urandom_range(0, 99) < 85)
            return tag_pool[$urandom_range(0, TAG_POOL_SIZE-1)];
        return TAG_W'($urandom);
    endfunction

    task automatic send_word(input logic [CMD_W-1:0]      cmd,
                             input logic [INDEX_IN_W-1:0] index,
                             input logic [ADDR_W-1:0]     addr,
                             input logic [WORD_W-1:0]     data);
        int unsigned line;
        int unsigned slot;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        line_index <= index;
        phys_address <= addr;
        fill_word <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        line = index % LINES;
        slot = line * WORDS + (addr >> OFFSET_LSB) % WORDS;
        if (cmd == CMD_FILL)
        begin
            mirror_live[line] = 1'b1;
            mirror_tag[line] = addr[ADDR_W-1:TAG_LSB];
            mirror_written[slot] = 1'b1;
        end
        else if (cmd == CMD_INVALIDATE)
        begin
            mirror_live = '0;
        end
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    // A hit on a word that was never filled is outside the contract, so such a
    // probe is turned into a tag miss.
    task automatic probe(input logic [INDEX_IN_W-1:0] index,
                         input logic [TAG_W-1:0]      tag,
                         input int unsigned           offset);
        int unsigned line;
        logic [ADDR_W-1:0] addr;
        line = index % LINES;
        addr = make_address(tag, offset);
        if (mirror_live[line] && mirror_tag[line] == tag
            && !mirror_written[line * WORDS + offset % WORDS])
            addr[TAG_LSB] = ~addr[TAG_LSB];
        send_word(CMD_PROBE, index, addr, $urandom);
    endtask

    task automatic fill_line(input logic [INDEX_IN_W-1:0] index,
                             input logic [TAG_W-1:0]      tag,
                             input int unsigned           count);
        int unsigned first;
        first = $urandom_range(0, WORDS-1);
        for (int k = 0; k < count; k++)
            send_word(CMD_FILL, index, make_address(tag, (first + k) % WORDS), $urandom);
    endtask

    task automatic run_random(input int unsigned target);
        int unsigned goal;
        int unsigned pick;
        int unsigned burst;
        int unsigned line;
        logic [INDEX_IN_W-1:0] index;
        logic [TAG_W-1:0] tag;
        goal = items_sent + target;
        while (items_sent < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                fill_line(pick_line(), pick_tag(), WORDS);
            end
            else if (pick < 80)
            begin
                burst = $urandom_range(1, 6);
                for (int k = 0; k < burst; k++)
                begin
                    index = pick_line();
                    line = index % LINES;
                    tag = (mirror_live[line] && $urandom_range(0, 99) < 75)
                          ? mirror_tag[line] : pick_tag();
                    probe(index, tag, $urandom_range(0, WORDS-1));
                end
            end
            else if (pick < 88)
            begin
                fill_line(pick_line(), pick_tag(), 1);
            end
            else if (pick < 92)
            begin
                fill_line(pick_line(), pick_tag(), $urandom_range(2, WORDS-1));
            end
            else if (pick < 95)
            begin
                send_word(CMD_INVALIDATE, INDEX_IN_W'($urandom), $urandom, $urandom);
            end
            else
            begin
                send_word(CMD_UNUSED, INDEX_IN_W'($urandom), $urandom, $urandom);
            end
        end
    endtask

    initial
    begin
        int unsigned guard;
        line_pool[0] = '0;
        line_pool[1] = '1;
        for (int k = 2; k < LINE_POOL_SIZE; k++)
            line_pool[k] = INDEX_IN_W'($urandom);
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int k = 2; k < TAG_POOL_SIZE; k++)
            tag_pool[k] = TAG_W'($urandom);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_word(CMD_PROBE, '0, make_address('0, 0), '0);
        for (int k = 0; k < WORDS; k++)
            send_word(CMD_FILL, '0, make_address('1, k), k[0] ? '1 : '0);
        probe('0, '1, WORDS-1);
        probe('0, '1, 0);
        probe('0, '0, 3);
        send_word(CMD_FILL, '1, make_address('0, 0), '1);
        probe('1, '0, 0);
        probe('1, 20'h00001, 4);
        send_word(CMD_UNUSED, '1, '1, '1);
        probe('0, '1, 1);
        send_word(CMD_INVALIDATE, INDEX_IN_W'($urandom), $urandom, $urandom);
        probe('0, '1, 2);
        send_word(CMD_FILL, '0, make_address('1, 3), $urandom);
        probe('0, '1, 5);
        probe('0, '1, 3);

        run_random(PHASE_ITEMS);
        idle_pct = 79;
        run_random(PHASE_ITEMS);
        idle_pct = 0;
        stall_pct <= 79;
        run_random(PHASE_ITEMS);
        idle_pct = 32;
        stall_pct <= 32;
        run_random(PHASE_ITEMS);
        idle_pct = 0;
        stall_pct <= 0;
        hold_request <= 1'b1;
        run_random(PHASE_ITEMS);

        in_valid <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (pending_count != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        run_done <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Ran %0d probes (%0d hits), %0d word fills and %0d invalidates,",
                 probe_count, hit_count, fill_count, wipe_count);
        $display("over four idle and stall mixes and one long output hold.");
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
